>>> hdl/idea_pkg.sv
// Package for the IDEA block cipher: widths, sequencer states and register indexes.
// Used by the channel interfaces and by idea_block_cipher.
`timescale 1ns / 1ps
`default_nettype none
package idea_pkg;
    localparam int WORD_W      = 16;
    localparam int BLOCK_W     = 64;
    localparam int REG_IDX_W   = 1;
    localparam int ROUND_COUNT_DEFAULT = 8;
    localparam int SUBKEY_DEPTH = 52;
    localparam int SK_IDX_W    = 6;

    localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef enum logic [3:0] {
        ST_KEYLOAD,
        ST_DEC_FETCH,
        ST_DEC_SORT,
        ST_INV_MUL,
        ST_INV_STORE,
        ST_IDLE,
        ST_MUL,
        ST_MIX,
        ST_DONE
    } idea_state_t;
endpackage
`default_nettype wire

>>> hdl/idea_if.sv
// Valid/ready channels carrying the key writes, the cipher command and block, and the result block.
// Depends on idea_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface idea_in_if;
    import idea_pkg::*;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [BLOCK_W-1:0] data_block;
    modport source (output valid, output cmd, output data_block, input ready);
    modport sink   (input valid, input cmd, input data_block, output ready);
endinterface

interface idea_out_if;
    import idea_pkg::*;
    logic               valid;
    logic               ready;
    logic [BLOCK_W-1:0] result_block;
    modport source (output valid, output result_block, input ready);
    modport sink   (input valid, input result_block, output ready);
endinterface

interface idea_cfg_if;
    import idea_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [BLOCK_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/idea_block_cipher.sv
// IDEA block cipher top level with a single shared modulo 65537 multiplier.
// Each block passes through the rounds in turn: six subkey slots and one mix step per round,
// then four output slots and one result step before the result is valid.
// One block is processed at a time; the input is not ready while a block is in progress.
// Reset and every key write rerun the key schedule: the encryption subkeys are loaded, then each
// decryption subkey is derived by inversion, negation or copy; no data is taken until then.
`timescale 1ns / 1ps
`default_nettype none
module idea_block_cipher
#(
    parameter int ROUND_COUNT = idea_pkg::ROUND_COUNT_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    idea_cfg_if.sink  cfg,
    idea_in_if.sink   in_ch,
    idea_out_if.source out_ch
);
    import idea_pkg::*;

    localparam int NKEYS = 6 * ROUND_COUNT + 4;

    idea_state_t state_reg, state_next;

    logic [BLOCK_W-1:0]   key_high_reg, key_low_reg;
    logic [2*BLOCK_W-1:0] krot_reg, krot_next;     // key rotated by 25 bits per group of 8
    logic [WORD_W-1:0]    enc_mem [SUBKEY_DEPTH];
    logic [WORD_W-1:0]    dec_mem [SUBKEY_DEPTH];

    logic [SK_IDX_W-1:0] idx_reg, idx_next;     // subkey index
    logic [4:0]          bit_reg, bit_next;     // exponent bit counter
    logic                phase_reg, phase_next; // square or multiply within a bit
    logic [3:0]          drnd_reg, drnd_next;   // decryption schedule round
    logic [2:0]          dslot_reg, dslot_next; // decryption schedule slot
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic [WORD_W-1:0]   base_reg, base_next;
    logic                cmd_reg, cmd_next;
    logic [WORD_W-1:0]   x0_reg, x1_reg, x2_reg, x3_reg;
    logic [WORD_W-1:0]   x0_next, x1_next, x2_next, x3_next;
    logic [WORD_W-1:0]   b_reg, b_next;
    logic [2:0]          step_reg, step_next;   // subkey slot within a round
    logic [3:0]          rnd_reg, rnd_next;
    logic [BLOCK_W-1:0]  res_reg, res_next;
    logic                ovalid_reg, ovalid_next;

    // Subkey memory ports.
    logic                enc_we, dec_we;
    logic [WORD_W-1:0]   enc_wdata, dec_wdata;
    logic [SK_IDX_W-1:0] rd_addr;
    logic [WORD_W-1:0]   enc_q, dec_q, key_rd;

    // Source of the encryption subkey for the current decryption slot.
    logic [SK_IDX_W-1:0] dsrc_base, dsrc_s, dsrc_addr;
    logic                dsrc_edge;

    // Shared multiplier.
    logic [WORD_W-1:0] mul_a, mul_b, mul_y;
    logic [2*WORD_W-1:0] mul_q;
    logic [WORD_W-1:0] mul_lo, mul_hi;

    always_comb
    begin
        mul_q  = mul_a * mul_b;
        mul_lo = mul_q[WORD_W-1:0];
        mul_hi = mul_q[2*WORD_W-1:WORD_W];
        if (mul_a == '0)
            mul_y = WORD_W'(17'd1 - {1'b0, mul_b});
        else if (mul_b == '0)
            mul_y = WORD_W'(17'd1 - {1'b0, mul_a});
        else
            mul_y = mul_lo - mul_hi + ((mul_lo < mul_hi) ? 16'd1 : 16'd0);
    end

    always_ff @(posedge clk)
    begin
        if (enc_we)
            enc_mem[idx_reg] <= enc_wdata;
        if (dec_we)
            dec_mem[idx_reg] <= dec_wdata;
        enc_q <= enc_mem[rd_addr];
        dec_q <= dec_mem[rd_addr];
    end

    assign key_rd = (cmd_reg == CMD_DECRYPT) ? dec_q : enc_q;

    always_comb
    begin
        dsrc_base = SK_IDX_W'(ROUND_COUNT) - SK_IDX_W'(drnd_reg);
        dsrc_s    = (dsrc_base << 2) + (dsrc_base << 1);
        dsrc_edge = (drnd_reg == '0) || (drnd_reg == 4'(ROUND_COUNT));
        case (dslot_reg)
            3'd0: dsrc_addr = dsrc_s;
            3'd1: dsrc_addr = dsrc_edge ? dsrc_s + 6'd1 : dsrc_s + 6'd2;
            3'd2: dsrc_addr = dsrc_edge ? dsrc_s + 6'd2 : dsrc_s + 6'd1;
            3'd3: dsrc_addr = dsrc_s + 6'd3;
            3'd4: dsrc_addr = dsrc_s - 6'd2;
            default: dsrc_addr = dsrc_s - 6'd1;
        endcase
    end

    always_comb
    begin
        logic dec_step;
        state_next = state_reg;
        idx_next = idx_reg; bit_next = bit_reg; phase_next = phase_reg;
        drnd_next = drnd_reg; dslot_next = dslot_reg; krot_next = krot_reg;
        acc_next = acc_reg; base_next = base_reg; cmd_next = cmd_reg;
        x0_next = x0_reg; x1_next = x1_reg; x2_next = x2_reg; x3_next = x3_reg;
        b_next = b_reg; step_next = step_reg; rnd_next = rnd_reg;
        res_next = res_reg; ovalid_next = ovalid_reg;
        enc_we = 1'b0; dec_we = 1'b0;
        enc_wdata = '0; dec_wdata = '0;
        dec_step = 1'b0;
        mul_a = acc_reg; mul_b = base_reg;

        if (out_ch.valid && out_ch.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_KEYLOAD:
            begin
                enc_we = 1'b1;
                case (idx_reg[2:0])
                    3'd0: enc_wdata = krot_reg[127:112];
                    3'd1: enc_wdata = krot_reg[111:96];
                    3'd2: enc_wdata = krot_reg[95:80];
                    3'd3: enc_wdata = krot_reg[79:64];
                    3'd4: enc_wdata = krot_reg[63:48];
                    3'd5: enc_wdata = krot_reg[47:32];
                    3'd6: enc_wdata = krot_reg[31:16];
                    default: enc_wdata = krot_reg[15:0];
                endcase
                if (idx_reg[2:0] == 3'd7)
                    krot_next = {krot_reg[102:0], krot_reg[127:103]};
                idx_next = idx_reg + 6'd1;
                if (idx_reg == 6'(SUBKEY_DEPTH - 1))
                begin
                    idx_next = '0;
                    drnd_next = '0;
                    dslot_next = '0;
                    state_next = ST_DEC_FETCH;
                end
            end
            ST_DEC_FETCH:
            begin
                state_next = ST_DEC_SORT;
            end
            ST_DEC_SORT:
            begin
                if (dslot_reg == 3'd0 || dslot_reg == 3'd3)
                begin
                    acc_next = 16'd1;
                    base_next = enc_q;
                    bit_next = '0;
                    phase_next = 1'b0;
                    state_next = ST_INV_MUL;
                end
                else
                begin
                    dec_we = 1'b1;
                    dec_wdata = (dslot_reg == 3'd1 || dslot_reg == 3'd2) ? 16'(-enc_q) : enc_q;
                    dec_step = 1'b1;
                end
            end
            ST_INV_MUL:
            begin
                // Square-and-multiply over the 16 set bits of 65535.
                if (!phase_reg)
                begin
                    mul_a = acc_reg; mul_b = base_reg;
                    acc_next = mul_y;
                    phase_next = 1'b1;
                end
                else
                begin
                    mul_a = base_reg; mul_b = base_reg;
                    base_next = mul_y;
                    phase_next = 1'b0;
                    bit_next = bit_reg + 5'd1;
                    if (bit_reg == 5'd15)
                        state_next = ST_INV_STORE;
                end
            end
            ST_INV_STORE:
            begin
                dec_we = 1'b1;
                dec_wdata = acc_reg;
                dec_step = 1'b1;
            end
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    cmd_next = in_ch.cmd;
                    x0_next = in_ch.data_block[63:48];
                    x1_next = in_ch.data_block[47:32];
                    x2_next = in_ch.data_block[31:16];
                    x3_next = in_ch.data_block[15:0];
                    idx_next = '0; step_next = '0; rnd_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // One subkey per cycle in index order; the key read is issued a cycle ahead.
                mul_a = key_rd;
                case (step_reg)
                    3'd0: mul_b = x0_reg;
                    3'd1: mul_b = x3_reg;
                    3'd2: mul_b = x0_reg ^ x2_reg;
                    default: mul_b = b_reg + (x1_reg ^ x3_reg);
                endcase
                case (step_reg)
                    3'd0:
                    begin
                        x0_next = mul_y;
                        idx_next = idx_reg + 6'd1;
                        step_next = 3'd4;
                    end
                    3'd4:
                    begin
                        // In the output step the sum goes to b, since x1 is still needed.
                        if (rnd_reg == 4'(ROUND_COUNT))
                            b_next = x2_reg + key_rd;
                        else
                            x1_next = x1_reg + key_rd;
                        idx_next = idx_reg + 6'd1;
                        step_next = 3'd5;
                    end
                    3'd5:
                    begin
                        if (rnd_reg == 4'(ROUND_COUNT))
                            x2_next = x1_reg + key_rd;
                        else
                            x2_next = x2_reg + key_rd;
                        idx_next = idx_reg + 6'd1;
                        step_next = 3'd1;
                    end
                    3'd1:
                    begin
                        x3_next = mul_y;
                        if (rnd_reg == 4'(ROUND_COUNT))
                        begin
                            idx_next = '0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 6'd1;
                            step_next = 3'd2;
                        end
                    end
                    3'd2:
                    begin
                        b_next = mul_y;
                        idx_next = idx_reg + 6'd1;
                        step_next = 3'd3;
                    end
                    default:
                    begin
                        acc_next = mul_y;
                        idx_next = idx_reg + 6'd1;
                        state_next = ST_MIX;
                    end
                endcase
            end
            ST_MIX:
            begin
                x0_next = x0_reg ^ acc_reg;
                x3_next = x3_reg ^ (b_reg + acc_reg);
                x1_next = x2_reg ^ acc_reg;
                x2_next = (b_reg + acc_reg) ^ x1_reg;
                b_next = '0;
                rnd_next = rnd_reg + 4'd1;
                step_next = '0;
                state_next = ST_MUL;
            end
            ST_DONE:
            begin
                if (!ovalid_reg)
                begin
                    res_next = {x0_reg, b_reg, x2_reg, x3_reg};
                    ovalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (dec_step)
        begin
            idx_next = idx_reg + 6'd1;
            if (dslot_reg == 3'd5)
            begin
                dslot_next = '0;
                drnd_next = drnd_reg + 4'd1;
            end
            else
                dslot_next = dslot_reg + 3'd1;
            state_next = (idx_reg == 6'(NKEYS - 1)) ? ST_IDLE : ST_DEC_FETCH;
        end

        rd_addr = (state_reg == ST_DEC_FETCH) ? dsrc_addr : idx_next;
    end

    // Key-port writes restart the schedule; the user must write them only while idle, as the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_KEYLOAD;
            idx_reg <= '0;
            ovalid_reg <= 1'b0;
            key_high_reg <= '0;
            key_low_reg <= '0;
            krot_reg <= '0;
            bit_reg <= '0;
            phase_reg <= 1'b0;
            drnd_reg <= '0;
            dslot_reg <= '0;
            step_reg <= '0;
            rnd_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            ovalid_reg <= ovalid_next;
            krot_reg <= krot_next;
            bit_reg <= bit_next;
            phase_reg <= phase_next;
            drnd_reg <= drnd_next;
            dslot_reg <= dslot_next;
            step_reg <= step_next;
            rnd_reg <= rnd_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_KEY_HIGH)
                begin
                    key_high_reg <= cfg.data;
                    krot_reg <= {cfg.data, key_low_reg};
                end
                else
                begin
                    key_low_reg <= cfg.data;
                    krot_reg <= {key_high_reg, cfg.data};
                end
                state_reg <= ST_KEYLOAD;
                idx_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next; base_reg <= base_next; cmd_reg <= cmd_next;
        x0_reg <= x0_next; x1_reg <= x1_next; x2_reg <= x2_next; x3_reg <= x3_next;
        b_reg <= b_next;
        res_reg <= res_next;
    end

    assign cfg.ready = 1'b1;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.result_block = res_reg;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("input taken while busy");
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !ovalid_reg) |=> ovalid_reg)
        else $error("result not presented");
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX) |-> (rnd_reg < 4'(ROUND_COUNT)))
        else $error("round counter overrun");
`endif
endmodule
`default_nettype wire
